// ===== hw/rtl/bfr_pkg.sv =====
package bfr_pkg;

    // Screen and font geometry
    localparam int SCREEN_W    = 240;
    localparam int SCREEN_H    = 160;
    localparam int FIRST_CODE  = 32;
    localparam int GLYPH_COUNT = 96;

    localparam int GLYPH_ROWS  = 8;
    localparam int GLYPH_COLS  = 8;
    localparam int GLYPH_PIX   = GLYPH_ROWS * GLYPH_COLS;
    localparam int GRAM_DEPTH  = GLYPH_COUNT * GLYPH_ROWS;
    localparam int GRAM_AW     = $clog2(GRAM_DEPTH);

    // Operation codes of the input word
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_CHAR  = 2'd1;
    localparam logic [1:0] OP_FONT  = 2'd2;
    localparam logic [1:0] OP_SKIP  = 2'd3;

    // Status codes of a result word
    localparam logic [1:0] ST_FINE   = 2'd0;
    localparam logic [1:0] ST_BOTTOM = 2'd1;
    localparam logic [1:0] ST_ESCAPE = 2'd2;

    // Input word: one operation with all its fields
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  char_code;
        logic [7:0]  start_x;
        logic [7:0]  start_y;
        logic [15:0] start_color;
        logic [6:0]  glyph_index;
        logic [2:0]  glyph_row;
        logic [7:0]  glyph_bits;
    } in_word_t;

    // Output word: one pixel write or one status word
    typedef struct packed {
        logic        write_enable;
        logic [15:0] pixel_addr;
        logic [15:0] pixel_color;
        logic [1:0]  status;
        logic        last;
    } out_word_t;

    // What the decoded input word asks of the controller
    typedef enum logic [1:0] {
        OUTCOME_NONE,
        OUTCOME_RESP,
        OUTCOME_DRAW
    } outcome_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic decode;
        logic load;
        logic emit;
        logic resp;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        outcome_t outcome;
        logic     load_done;
        logic     emit_last;
        logic     slot_free;
    } dp_status_t;

endpackage

// ===== hw/rtl/bfr_glyph_ram.sv =====
module bfr_glyph_ram (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [bfr_pkg::GRAM_AW-1:0] wr_addr,
    input  logic [7:0]                  wr_data,
    input  logic                        rd_en,
    input  logic [bfr_pkg::GRAM_AW-1:0] rd_addr,
    output logic [7:0]                  rd_data
);
    import bfr_pkg::*;

    logic [7:0] mem [GRAM_DEPTH];
    logic [7:0] rd_data_reg;

    // Write one font row, read one font row with registered data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/bfr_datapath.sv =====
module bfr_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  bfr_pkg::in_word_t   in_data,
    input  bfr_pkg::ctrl_cmd_t  cmd,
    output bfr_pkg::dp_status_t status,
    output logic                out_valid,
    input  logic                out_ready,
    output bfr_pkg::out_word_t  out_data
);
    import bfr_pkg::*;

    localparam int MAX_W  = (SCREEN_W > 255) ? SCREEN_W : 255;
    localparam int MAX_H  = (SCREEN_H > 255) ? SCREEN_H : 255;
    localparam int CX_W   = $clog2(MAX_W + 9);
    localparam int CY_W   = $clog2(MAX_H + 9);
    localparam int CMP_W  = $clog2(MAX_W + MAX_H + 64);
    localparam int BASE_R = $clog2((SCREEN_H + 16) * SCREEN_W + 2 * MAX_W + 64);
    localparam int BASE_W = (BASE_R > 16) ? BASE_R : 16;

    localparam logic [1:0] RUN_IDLE   = 2'd0;
    localparam logic [1:0] RUN_ACTIVE = 2'd1;
    localparam logic [1:0] RUN_BOTTOM = 2'd2;
    localparam logic [1:0] RUN_BADESC = 2'd3;

    localparam logic [2:0] ESC_NONE    = 3'd0;
    localparam logic [2:0] ESC_BRACKET = 3'd1;
    localparam logic [2:0] ESC_ZERO    = 3'd2;
    localparam logic [2:0] ESC_X       = 3'd3;

    localparam logic [7:0] CH_NL       = 8'h0A;
    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_X        = 8'h78;
    localparam logic [15:0] COLOR_MASK = 16'h7FFF;

    // Decode one hex digit: {valid, value}
    function automatic logic [4:0] hex_of(input logic [7:0] ch);
        logic [4:0] res;
        res = '0;
        if (ch >= 8'h30 && ch <= 8'h39)
        begin
            res = {1'b1, 4'(ch - 8'h30)};
        end
        else if (ch >= 8'h61 && ch <= 8'h66)
        begin
            res = {1'b1, 4'(ch - 8'h57)};
        end
        else if (ch >= 8'h41 && ch <= 8'h46)
        begin
            res = {1'b1, 4'(ch - 8'h37)};
        end
        return res;
    endfunction

    // Lowest set bit position of the pixel mask
    function automatic logic [5:0] low_index(input logic [GLYPH_PIX-1:0] m);
        logic [5:0] idx;
        idx = '0;
        for (int i = GLYPH_PIX - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                idx = 6'(i);
            end
        end
        return idx;
    endfunction

    in_word_t            in_reg;
    logic [CX_W-1:0]     cursor_x_reg, cursor_x_next;
    logic [CY_W-1:0]     cursor_y_reg, cursor_y_next;
    logic [7:0]          line_start_reg, line_start_next;
    logic [15:0]         color_reg, color_next;
    logic [2:0]          esc_phase_reg, esc_phase_next;
    logic [15:0]         hex_value_reg, hex_value_next;
    logic [2:0]          hex_digits_reg, hex_digits_next;
    logic [1:0]          run_reg, run_next;
    logic [1:0]          resp_status_reg, resp_status_next;
    logic [6:0]          glyph_reg;
    logic [7:0]          colmask_reg, colmask_next;
    logic [BASE_W-1:0]   base_reg;
    logic [3:0]          load_cnt_reg;
    logic [GLYPH_PIX-1:0] mask_reg;
    out_word_t           out_reg;
    logic                out_valid_reg;

    outcome_t            outcome;
    logic [CX_W-1:0]     draw_x;
    logic [CY_W-1:0]     draw_y;
    logic [CMP_W-1:0]    wrap_y;
    logic                gram_wr_en;
    logic [4:0]          hex_digit;
    logic [7:0]          ch;
    logic [7:0]          rd_data;
    logic [7:0]          row_bits;
    logic [2:0]          load_cnt_m1;
    logic [GLYPH_PIX-1:0] mask_rest;
    logic [5:0]          pix_idx;
    logic [BASE_W-1:0]   pix_sum;
    logic                slot_free;

    assign ch        = in_reg.char_code;
    assign hex_digit = hex_of(ch);

    // Decode the captured word against the text state
    always_comb
    begin
        cursor_x_next    = cursor_x_reg;
        cursor_y_next    = cursor_y_reg;
        line_start_next  = line_start_reg;
        color_next       = color_reg;
        esc_phase_next   = esc_phase_reg;
        hex_value_next   = hex_value_reg;
        hex_digits_next  = hex_digits_reg;
        run_next         = run_reg;
        resp_status_next = ST_FINE;
        outcome          = OUTCOME_NONE;
        gram_wr_en       = 1'b0;
        draw_x           = cursor_x_reg;
        draw_y           = cursor_y_reg;
        wrap_y           = '0;
        unique case (in_reg.op)
            OP_START:
            begin
                outcome         = OUTCOME_RESP;
                cursor_x_next   = CX_W'(in_reg.start_x);
                line_start_next = in_reg.start_x;
                cursor_y_next   = CY_W'(in_reg.start_y);
                color_next      = in_reg.start_color;
                esc_phase_next  = ESC_NONE;
                hex_value_next  = '0;
                hex_digits_next = '0;
                if (CMP_W'(in_reg.start_y) + CMP_W'(GLYPH_ROWS) > CMP_W'(SCREEN_H))
                begin
                    run_next         = RUN_BOTTOM;
                    resp_status_next = ST_BOTTOM;
                end
                else
                begin
                    run_next = RUN_ACTIVE;
                end
            end
            OP_CHAR:
            begin
                outcome = OUTCOME_RESP;
                if (run_reg != RUN_ACTIVE)
                begin
                    if (run_reg == RUN_BOTTOM)
                    begin
                        resp_status_next = ST_BOTTOM;
                    end
                    else if (run_reg == RUN_BADESC)
                    begin
                        resp_status_next = ST_ESCAPE;
                    end
                end
                else if (esc_phase_reg != ESC_NONE)
                begin
                    // Walk the color escape, stop on any unexpected byte
                    case (esc_phase_reg)
                        ESC_BRACKET:
                        begin
                            if (ch == CH_LBRACKET)
                            begin
                                esc_phase_next = ESC_ZERO;
                            end
                            else
                            begin
                                run_next = RUN_BADESC;
                            end
                        end
                        ESC_ZERO:
                        begin
                            if (ch == CH_ZERO)
                            begin
                                esc_phase_next = ESC_X;
                            end
                            else
                            begin
                                run_next = RUN_BADESC;
                            end
                        end
                        ESC_X:
                        begin
                            if (ch == CH_X)
                            begin
                                esc_phase_next = ESC_X + 3'd1;
                            end
                            else
                            begin
                                run_next = RUN_BADESC;
                            end
                        end
                        default:
                        begin
                            if (ch == CH_RBRACKET)
                            begin
                                if (hex_digits_reg == 3'd0)
                                begin
                                    run_next = RUN_BADESC;
                                end
                                else
                                begin
                                    color_next     = hex_value_reg & COLOR_MASK;
                                    esc_phase_next = ESC_NONE;
                                end
                            end
                            else if (!hex_digit[4] || hex_digits_reg >= 3'd4)
                            begin
                                run_next = RUN_BADESC;
                            end
                            else
                            begin
                                hex_value_next  = {hex_value_reg[11:0], hex_digit[3:0]};
                                hex_digits_next = hex_digits_reg + 3'd1;
                            end
                        end
                    endcase
                    if (run_next == RUN_BADESC)
                    begin
                        esc_phase_next   = ESC_NONE;
                        resp_status_next = ST_ESCAPE;
                    end
                end
                else if (ch == 8'd0)
                begin
                    run_next = RUN_IDLE;
                end
                else if (ch < 8'(FIRST_CODE))
                begin
                    if (ch == CH_NL)
                    begin
                        cursor_x_next = CX_W'(line_start_reg);
                        cursor_y_next = cursor_y_reg + CY_W'(GLYPH_ROWS);
                        wrap_y        = CMP_W'(cursor_y_reg) + CMP_W'(2 * GLYPH_ROWS);
                        if (wrap_y > CMP_W'(SCREEN_H))
                        begin
                            run_next         = RUN_BOTTOM;
                            resp_status_next = ST_BOTTOM;
                        end
                    end
                    else if (ch == CH_ESC)
                    begin
                        esc_phase_next  = ESC_BRACKET;
                        hex_value_next  = '0;
                        hex_digits_next = '0;
                    end
                end
                else if ({1'b0, ch} < 9'(FIRST_CODE + GLYPH_COUNT))
                begin
                    // Wrap at the right edge, then draw unless off the bottom
                    if (CMP_W'(cursor_x_reg) + CMP_W'(GLYPH_COLS) > CMP_W'(SCREEN_W))
                    begin
                        draw_x = CX_W'(line_start_reg);
                        draw_y = cursor_y_reg + CY_W'(GLYPH_ROWS);
                        wrap_y = CMP_W'(cursor_y_reg) + CMP_W'(2 * GLYPH_ROWS);
                    end
                    cursor_y_next = draw_y;
                    if (wrap_y > CMP_W'(SCREEN_H))
                    begin
                        cursor_x_next    = draw_x;
                        run_next         = RUN_BOTTOM;
                        resp_status_next = ST_BOTTOM;
                    end
                    else
                    begin
                        cursor_x_next = draw_x + CX_W'(GLYPH_COLS);
                        outcome       = OUTCOME_DRAW;
                    end
                end
            end
            OP_FONT:
            begin
                gram_wr_en = (in_reg.glyph_index < 7'(GLYPH_COUNT));
            end
            default:
            begin
                outcome = OUTCOME_NONE;
            end
        endcase
    end

    // Columns of the glyph that land on the screen
    always_comb
    begin
        for (int j = 0; j < GLYPH_COLS; j++)
        begin
            colmask_next[j] = (CMP_W'(draw_x) + CMP_W'(j) < CMP_W'(SCREEN_W));
        end
    end

    // Hold text state and advance it on decode; count font row reads; track the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
            line_start_reg <= '0;
            color_reg      <= '0;
            esc_phase_reg  <= ESC_NONE;
            hex_value_reg  <= '0;
            hex_digits_reg <= '0;
            run_reg        <= RUN_IDLE;
            out_valid_reg  <= 1'b0;
            load_cnt_reg   <= '0;
        end
        else
        begin
            if (cmd.decode)
            begin
                cursor_x_reg   <= cursor_x_next;
                cursor_y_reg   <= cursor_y_next;
                line_start_reg <= line_start_next;
                color_reg      <= color_next;
                esc_phase_reg  <= esc_phase_next;
                hex_value_reg  <= hex_value_next;
                hex_digits_reg <= hex_digits_next;
                run_reg        <= run_next;
                load_cnt_reg   <= '0;
            end
            else if (cmd.load)
            begin
                load_cnt_reg <= load_cnt_reg + 4'd1;
            end
            if (cmd.emit || cmd.resp)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Font row read for the glyph being drawn
    assign load_cnt_m1 = load_cnt_reg[2:0] - 3'd1;

    always_comb
    begin
        for (int j = 0; j < GLYPH_COLS; j++)
        begin
            row_bits[j] = rd_data[GLYPH_COLS - 1 - j] & colmask_reg[j];
        end
    end

    bfr_glyph_ram u_gram (
        .clk     (clk),
        .wr_en   (cmd.decode && gram_wr_en),
        .wr_addr (GRAM_AW'({in_reg.glyph_index, in_reg.glyph_row})),
        .wr_data (in_reg.glyph_bits),
        .rd_en   (cmd.load && !load_cnt_reg[3]),
        .rd_addr (GRAM_AW'({glyph_reg, load_cnt_reg[2:0]})),
        .rd_data (rd_data)
    );

    // Next pixel to write and what remains after it
    assign mask_rest = mask_reg & (mask_reg - GLYPH_PIX'(1));
    assign pix_idx   = low_index(mask_reg);
    assign pix_sum   = base_reg + BASE_W'(pix_idx[5:3]) * BASE_W'(SCREEN_W)
                       + BASE_W'(pix_idx[2:0]);
    assign slot_free = !out_valid_reg || out_ready;

    // Payload registers: input word, draw setup, pixel mask, output word
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg <= in_data;
        end
        if (cmd.decode)
        begin
            resp_status_reg <= resp_status_next;
            glyph_reg       <= 7'(ch - 8'(FIRST_CODE));
            colmask_reg     <= colmask_next;
            base_reg        <= BASE_W'(draw_y) * BASE_W'(SCREEN_W) + BASE_W'(draw_x);
        end
        if (cmd.load && load_cnt_reg != 4'd0)
        begin
            for (int r = 0; r < GLYPH_ROWS; r++)
            begin
                if (load_cnt_m1 == 3'(r))
                begin
                    mask_reg[r * GLYPH_COLS +: GLYPH_COLS] <= row_bits;
                end
            end
        end
        if (cmd.emit)
        begin
            mask_reg <= mask_rest;
            if (mask_reg != '0)
            begin
                out_reg.write_enable <= 1'b1;
                out_reg.pixel_addr   <= pix_sum[15:0];
                out_reg.pixel_color  <= color_reg;
                out_reg.status       <= ST_FINE;
                out_reg.last         <= (mask_rest == '0);
            end
            else
            begin
                out_reg <= '{write_enable: 1'b0, pixel_addr: 16'd0, pixel_color: 16'd0,
                             status: ST_FINE, last: 1'b1};
            end
        end
        else if (cmd.resp)
        begin
            out_reg <= '{write_enable: 1'b0, pixel_addr: 16'd0, pixel_color: 16'd0,
                         status: resp_status_reg, last: 1'b1};
        end
    end

    assign status.outcome   = outcome;
    assign status.load_done = load_cnt_reg[3];
    assign status.emit_last = (mask_rest == '0);
    assign status.slot_free = slot_free;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== hw/rtl/bfr_ctrl.sv =====
module bfr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bfr_pkg::dp_status_t status,
    output bfr_pkg::ctrl_cmd_t  cmd
);
    import bfr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RESP,
        S_LOAD,
        S_EMIT
    } state_t;

    state_t state_reg;
    logic   in_ready_reg;

    // Sequence one word: decode, then a status word, a glyph draw, or nothing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready_reg)
                    begin
                        state_reg    <= S_DECODE;
                        in_ready_reg <= 1'b0;
                    end
                end
                S_DECODE:
                begin
                    unique case (status.outcome)
                        OUTCOME_RESP: state_reg <= S_RESP;
                        OUTCOME_DRAW: state_reg <= S_LOAD;
                        default:
                        begin
                            state_reg    <= S_IDLE;
                            in_ready_reg <= 1'b1;
                        end
                    endcase
                end
                S_RESP:
                begin
                    if (status.slot_free)
                    begin
                        state_reg    <= S_IDLE;
                        in_ready_reg <= 1'b1;
                    end
                end
                S_LOAD:
                begin
                    if (status.load_done)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (status.slot_free && status.emit_last)
                    begin
                        state_reg    <= S_IDLE;
                        in_ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg    <= S_IDLE;
                    in_ready_reg <= 1'b1;
                end
            endcase
        end
    end

    // Drive datapath commands
    assign cmd.capture = in_valid && in_ready_reg;
    assign cmd.decode  = (state_reg == S_DECODE);
    assign cmd.load    = (state_reg == S_LOAD);
    assign cmd.resp    = (state_reg == S_RESP) && status.slot_free;
    assign cmd.emit    = (state_reg == S_EMIT) && status.slot_free;

    assign in_ready = in_ready_reg;

endmodule

// ===== hw/rtl/bitmap_font_text_renderer.sv =====
// Channel   Direction  Handshake             Word
// input     in         in_valid / in_ready   in_data  (bfr_pkg::in_word_t)
// output    out        out_valid / out_ready out_data (bfr_pkg::out_word_t)
//
// A start, control or escape word is answered with one status word; a font row write with none.
// A drawn character first reads its eight font rows through the single glyph RAM read port,
// then writes one pixel a cycle while the output is not stalled (one non-write word if none is set).
// Reset clears the text state; the glyph RAM holds nothing until written.
// A stalled output holds the pending word; the block waits on it and takes
// a new input word only after the last result of the current one is registered.
module bitmap_font_text_renderer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bfr_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output bfr_pkg::out_word_t out_data
);
    import bfr_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    bfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (dp_status),
        .cmd      (cmd)
    );

    bfr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (dp_status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== verif/testbench.sv =====
module testbench;
    import bfr_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_WORDS = 305;
    localparam int DRAIN_CYCLES = 100;

    localparam logic [15:0] COLOR_MASK = 16'h7FFF;
    localparam logic [7:0]  GLYPH_FULL = 8'hFF;

    typedef enum logic [1:0] {RUN_IDLE, RUN_ACTIVE, RUN_OFF_BOTTOM, RUN_BAD_ESC} run_t;
    typedef enum logic [2:0] {ESC_NONE, ESC_BRACKET, ESC_ZERO, ESC_X, ESC_DIGITS} esc_t;

    localparam logic [7:0] CH_END    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_BLOCK  = 8'h7F;

    typedef struct {
        in_word_t   word;
        bit         typed;
        logic [1:0] status;
    } probe_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_word_t  in_data;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_data;

    // Text state of the renderer as seen from outside
    int unsigned cur_x;
    int unsigned cur_y;
    int unsigned line_x;
    logic [15:0] ink;
    esc_t        esc;
    logic [15:0] hex_acc;
    int unsigned hex_count;
    run_t        run;
    logic [7:0]  font_rows [GRAM_DEPTH];
    logic [7:0]  rows_loaded [GLYPH_COUNT] = '{default: '0};
    int unsigned font_focus = 0;

    out_word_t caused_words[$];
    out_word_t fb_words_due[$];

    int  cycles = 0;
    int  failures = 0;
    int  words_sent = 0;
    int  results_checked = 0;
    int  pixel_writes = 0;
    int  halts_bottom = 0;
    int  halts_escape = 0;
    int  ready_hold = 0;
    bit  steady = 1'b0;

    bitmap_font_text_renderer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk) cycles <= cycles + 1;

    function automatic int pick_wait();
        return steady ? 0 : $urandom_range(0, 3);
    endfunction

    function automatic out_word_t status_word(input logic [1:0] st);
        out_word_t o;
        o = '0;
        o.status = st;
        o.last = 1'b1;
        return o;
    endfunction

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    // Stop the string and report why
    task automatic halt(input run_t why);
        run = why;
        esc = ESC_NONE;
        if (why == RUN_OFF_BOTTOM)
        begin
            halts_bottom++;
            caused_words.push_back(status_word(ST_BOTTOM));
        end
        else
        begin
            halts_escape++;
            caused_words.push_back(status_word(ST_ESCAPE));
        end
    endtask

    // Advance to the next text line; false when it no longer fits
    function automatic bit new_line();
        cur_y += 8;
        cur_x = line_x;
        return cur_y + 8 <= SCREEN_H;
    endfunction

    task automatic escape_byte(input logic [7:0] c);
        int digit;
        case (esc)
            ESC_BRACKET:
            begin
                if (c != CH_LBRACK)
                begin
                    halt(RUN_BAD_ESC);
                    return;
                end
                esc = ESC_ZERO;
            end
            ESC_ZERO:
            begin
                if (c != CH_ZERO)
                begin
                    halt(RUN_BAD_ESC);
                    return;
                end
                esc = ESC_X;
            end
            ESC_X:
            begin
                if (c != CH_X)
                begin
                    halt(RUN_BAD_ESC);
                    return;
                end
                esc = ESC_DIGITS;
            end
            default:
            begin
                if (c == CH_RBRACK)
                begin
                    if (hex_count == 0)
                    begin
                        halt(RUN_BAD_ESC);
                        return;
                    end
                    ink = hex_acc & COLOR_MASK;
                    esc = ESC_NONE;
                end
                else
                begin
                    digit = hex_nibble(c);
                    if (digit < 0 || hex_count >= 4)
                    begin
                        halt(RUN_BAD_ESC);
                        return;
                    end
                    hex_acc = {hex_acc[11:0], 4'(digit)};
                    hex_count++;
                end
            end
        endcase
        caused_words.push_back(status_word(ST_FINE));
    endtask

    task automatic char_byte(input logic [7:0] c);
        int unsigned g;
        logic [7:0]  bits;
        out_word_t   pix;
        // hold the string while idle or stopped
        if (run != RUN_ACTIVE)
        begin
            caused_words.push_back(status_word(run == RUN_OFF_BOTTOM ? ST_BOTTOM :
                                               run == RUN_BAD_ESC ? ST_ESCAPE : ST_FINE));
            return;
        end
        if (esc != ESC_NONE)
        begin
            escape_byte(c);
            return;
        end
        if (c == CH_END)
            run = RUN_IDLE;
        else if (c < FIRST_CODE)
        begin
            if (c == CH_NL)
            begin
                if (!new_line())
                begin
                    halt(RUN_OFF_BOTTOM);
                    return;
                end
            end
            else if (c == CH_ESC)
            begin
                esc = ESC_BRACKET;
                hex_acc = '0;
                hex_count = 0;
            end
        end
        else if (c < FIRST_CODE + GLYPH_COUNT)
        begin
            // wrap at the right edge before drawing
            if (cur_x + 8 > SCREEN_W)
            begin
                if (!new_line())
                begin
                    halt(RUN_OFF_BOTTOM);
                    return;
                end
            end
            g = c - FIRST_CODE;
            for (int row = 0; row < GLYPH_ROWS; row++)
            begin
                bits = font_rows[g * GLYPH_ROWS + row];
                for (int col = 0; col < GLYPH_COLS; col++)
                begin
                    if (bits[7 - col] && cur_x + col < SCREEN_W)
                    begin
                        pix = '0;
                        pix.write_enable = 1'b1;
                        pix.pixel_addr = 16'((cur_y + row) * SCREEN_W + cur_x + col);
                        pix.pixel_color = ink;
                        caused_words.push_back(pix);
                    end
                end
            end
            cur_x += 8;
        end
        if (caused_words.size() == 0)
            caused_words.push_back(status_word(ST_FINE));
        else
            caused_words[$].last = 1'b1;
    endtask

    // Work out every result word that one input word causes
    task automatic render_word(input in_word_t w);
        caused_words.delete();
        case (w.op)
            OP_FONT:
            begin
                if (w.glyph_index < GLYPH_COUNT)
                begin
                    font_rows[w.glyph_index * GLYPH_ROWS + w.glyph_row] = w.glyph_bits;
                    rows_loaded[w.glyph_index][w.glyph_row] = 1'b1;
                end
            end
            OP_SKIP: ;
            OP_START:
            begin
                cur_x = w.start_x;
                line_x = w.start_x;
                cur_y = w.start_y;
                ink = w.start_color;
                esc = ESC_NONE;
                hex_acc = '0;
                hex_count = 0;
                if (cur_y + 8 > SCREEN_H)
                    halt(RUN_OFF_BOTTOM);
                else
                begin
                    run = RUN_ACTIVE;
                    caused_words.push_back(status_word(ST_FINE));
                end
            end
            default: char_byte(w.char_code);
        endcase
    endtask

    function automatic in_word_t start_word(input logic [7:0] x, input logic [7:0] y,
                                            input logic [15:0] color);
        in_word_t w;
        w = '0;
        w.op = OP_START;
        w.start_x = x;
        w.start_y = y;
        w.start_color = color;
        return w;
    endfunction

    function automatic in_word_t char_word(input logic [7:0] c);
        in_word_t w;
        w = '0;
        w.op = OP_CHAR;
        w.char_code = c;
        return w;
    endfunction

    function automatic in_word_t font_word(input logic [6:0] g, input logic [2:0] r,
                                           input logic [7:0] bits);
        in_word_t w;
        w = '0;
        w.op = OP_FONT;
        w.glyph_index = g;
        w.glyph_row = r;
        w.glyph_bits = bits;
        return w;
    endfunction

    function automatic in_word_t skip_word();
        in_word_t w;
        w = '0;
        w.op = OP_SKIP;
        return w;
    endfunction

    function automatic probe_t probe(input in_word_t w, input bit typed = 1'b0,
                                     input logic [1:0] st = ST_FINE);
        probe_t p;
        p.word = w;
        p.typed = typed;
        p.status = st;
        return p;
    endfunction

    function automatic logic [7:0] hex_char();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(0, 21)];
    endfunction

    function automatic logic [7:0] ready_glyph_code();
        int unsigned pool[$];
        for (int g = 0; g < GLYPH_COUNT; g++)
            if (rows_loaded[g] == GLYPH_FULL)
                pool.push_back(g);
        return 8'(FIRST_CODE + pool[$urandom_range(0, pool.size() - 1)]);
    endfunction

    // Mostly the next byte of a well-formed escape, now and then a broken one
    function automatic logic [7:0] escape_char();
        logic [7:0] c;
        case (esc)
            ESC_BRACKET: c = CH_LBRACK;
            ESC_ZERO:    c = CH_ZERO;
            ESC_X:       c = CH_X;
            default:
            begin
                if (hex_count == 0 || (hex_count < 4 && $urandom_range(0, 2) != 0))
                    c = hex_char();
                else if (hex_count == 4 && $urandom_range(0, 9) == 0)
                    c = hex_char();
                else
                    c = CH_RBRACK;
            end
        endcase
        if ($urandom_range(0, 99) < 6)
        begin
            case ($urandom_range(0, 3))
                0:       c = CH_END;
                1:       c = hex_char();
                2:       c = CH_RBRACK;
                default: c = 8'($urandom);
            endcase
        end
        return c;
    endfunction

    function automatic in_word_t next_word();
        in_word_t   w;
        logic [63:0] noise;
        int          pick;
        noise = {$urandom, $urandom};
        w = noise[$bits(in_word_t)-1:0];
        pick = $urandom_range(0, 99);
        // restart most stopped or finished strings
        if (run != RUN_ACTIVE && pick >= 14 && $urandom_range(0, 9) < 6)
            pick = 8;
        if (pick < 6)
        begin
            w.op = OP_FONT;
            if (rows_loaded[font_focus] == GLYPH_FULL)
                font_focus = $urandom_range(0, GLYPH_COUNT - 1);
            w.glyph_index = 7'(font_focus);
            for (int r = GLYPH_ROWS - 1; r >= 0; r--)
                if (!rows_loaded[font_focus][r])
                    w.glyph_row = 3'(r);
            if ($urandom_range(0, 9) == 0)
                w.glyph_bits = GLYPH_FULL;
            if ($urandom_range(0, 9) == 0)
                w.glyph_index = 7'($urandom_range(GLYPH_COUNT, 127));
        end
        else if (pick < 8)
            w.op = OP_SKIP;
        else if (pick < 14)
        begin
            w.op = OP_START;
            w.start_x = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(SCREEN_W, 255))
                                                     : 8'($urandom_range(0, SCREEN_W - 1));
            w.start_y = ($urandom_range(0, 9) < 2) ? 8'($urandom_range(SCREEN_H - 7, 255))
                                                    : 8'($urandom_range(0, SCREEN_H - 8));
        end
        else
        begin
            w.op = OP_CHAR;
            if (run == RUN_ACTIVE && esc != ESC_NONE)
                w.char_code = escape_char();
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    w.char_code = ready_glyph_code();
                else if (pick < 79)
                    w.char_code = CH_NL;
                else if (pick < 88)
                    w.char_code = CH_ESC;
                else if (pick < 91)
                    w.char_code = CH_END;
                else if (pick < 96)
                    w.char_code = 8'($urandom_range(0, FIRST_CODE - 1));
                else
                    w.char_code = 8'($urandom_range(FIRST_CODE + GLYPH_COUNT, 255));
                // never draw a glyph that is only partly loaded
                if (run == RUN_ACTIVE && w.char_code >= FIRST_CODE &&
                    w.char_code < FIRST_CODE + GLYPH_COUNT &&
                    rows_loaded[w.char_code - FIRST_CODE] != GLYPH_FULL)
                    w.char_code = ready_glyph_code();
            end
        end
        return w;
    endfunction

    // Queue the results of one word, then hand it over; call at a falling edge
    task automatic issue(input in_word_t w, input bit typed, input logic [1:0] typed_status);
        int gap;
        render_word(w);
        if (typed)
            fb_words_due.push_back(status_word(typed_status));
        else
            foreach (caused_words[k])
                fb_words_due.push_back(caused_words[k]);
        gap = pick_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        words_sent++;
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endfunction

    // Compare each accepted result word with the oldest one due
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (fb_words_due.size() == 0)
            begin
                $error("result word with nothing due: we %0b addr %0h color %0h status %0d last %0b",
                       out_data.write_enable, out_data.pixel_addr, out_data.pixel_color,
                       out_data.status, out_data.last);
                failures++;
            end
            else
            begin
                want = fb_words_due.pop_front();
                check_field("write_enable", 16'(want.write_enable), 16'(out_data.write_enable));
                check_field("pixel_addr", want.pixel_addr, out_data.pixel_addr);
                check_field("pixel_color", want.pixel_color, out_data.pixel_color);
                check_field("status", 16'(want.status), 16'(out_data.status));
                check_field("last", 16'(want.last), 16'(out_data.last));
            end
            if (out_data.write_enable === 1'b1)
                pixel_writes++;
            results_checked++;
            ready_hold = pick_wait();
        end
    end

    // Stall the result side for the drawn number of cycles after each word
    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            out_ready <= 1'b0;
            ready_hold--;
        end
        else
            out_ready <= 1'b1;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d words still due", cycles, fb_words_due.size());
        $display("bitmap_font_text_renderer verification failed");
        $finish;
    end

    initial
    begin
        in_word_t    w;
        probe_t      plan[$];
        int          counted;
        bit          drained;
        int unsigned preload [9];

        preload = '{0, 1, 95, 16, 17, 33, 34, 65, 66};
        counted = 0;
        drained = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cur_x = 0;
        cur_y = 0;
        line_x = 0;
        ink = '0;
        esc = ESC_NONE;
        hex_acc = '0;
        hex_count = 0;
        run = RUN_IDLE;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Load a few glyphs: blank, solid, edge pixels, and random ones
        foreach (preload[i])
            for (int r = 0; r < GLYPH_ROWS; r++)
                issue(font_word(7'(preload[i]), 3'(r),
                                preload[i] == 0  ? 8'h00 :
                                preload[i] == 95 ? GLYPH_FULL :
                                preload[i] == 1  ? (r[0] ? 8'h01 : 8'h80) : 8'($urandom)),
                      1'b0, ST_FINE);

        // Directed words
        plan.push_back(probe(char_word(CH_A), 1'b1, ST_FINE));
        plan.push_back(probe(skip_word()));
        plan.push_back(probe(font_word(7'd127, 3'd7, GLYPH_FULL)));
        plan.push_back(probe(start_word(8'd0, 8'd0, 16'hFFFF), 1'b1, ST_FINE));
        plan.push_back(probe(char_word(CH_BLOCK)));
        plan.push_back(probe(char_word(CH_SPACE)));
        plan.push_back(probe(char_word(CH_NL)));
        plan.push_back(probe(char_word(CH_ESC)));
        plan.push_back(probe(char_word(CH_LBRACK)));
        plan.push_back(probe(char_word(CH_ZERO)));
        plan.push_back(probe(char_word(CH_X)));
        plan.push_back(probe(char_word(CH_LOW_F)));
        plan.push_back(probe(char_word(CH_UP_F)));
        plan.push_back(probe(char_word(CH_LOW_F)));
        plan.push_back(probe(char_word(CH_UP_F)));
        plan.push_back(probe(char_word(CH_RBRACK)));
        plan.push_back(probe(char_word(CH_BANG)));
        plan.push_back(probe(start_word(8'd232, 8'd152, 16'h8001), 1'b1, ST_FINE));
        plan.push_back(probe(char_word(CH_BLOCK)));
        plan.push_back(probe(char_word(CH_BANG), 1'b1, ST_BOTTOM));
        plan.push_back(probe(start_word(8'd0, 8'd153, 16'h0000), 1'b1, ST_BOTTOM));
        plan.push_back(probe(start_word(8'd255, 8'd0, 16'h1234), 1'b1, ST_FINE));
        plan.push_back(probe(char_word(CH_BLOCK)));
        plan.push_back(probe(char_word(CH_ESC)));
        plan.push_back(probe(char_word(CH_RBRACK), 1'b1, ST_ESCAPE));
        foreach (plan[i])
            issue(plan[i].word, plan[i].typed, plan[i].status);

        // Random strings with font updates and noise
        while (counted < RANDOM_WORDS)
        begin
            steady = ((counted / 50) % 3 == 1);
            if (counted == RANDOM_WORDS / 2 && !drained)
            begin
                in_valid <= 1'b0;
                do
                    @(negedge clk);
                while (fb_words_due.size() != 0);
                drained = 1'b1;
            end
            w = next_word();
            issue(w, 1'b0, ST_FINE);
            if (w.op == OP_CHAR || w.op == OP_START ||
                (w.op == OP_FONT && w.glyph_index < GLYPH_COUNT))
                counted++;
        end
        in_valid <= 1'b0;

        while (fb_words_due.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d input words; checked %0d result words, %0d of them pixel writes.",
                 words_sent, results_checked, pixel_writes);
        $display("Strings stopped off the bottom %0d times and on a bad escape %0d times.",
                 halts_bottom, halts_escape);
        if (failures == 0)
            $display("bitmap_font_text_renderer verification clean");
        else
            $display("bitmap_font_text_renderer verification failed");
        $finish;
    end

endmodule
